// ===== rtl/core/sobm_pkg.sv =====
// Package for the Sobel edge magnitude block: word types, geometry struct, constants.
// No dependencies; sobm_front, sobm_back and the top level refer to it by scoped names.
package sobm_pkg;

    localparam int MAX_WIDTH_DEF = 8192;
    localparam int GEOM_W        = 15;   // holds a column count up to 16384
    localparam int CFG_W         = 14;
    localparam int PIX_W         = 8;
    localparam int GRAD_W        = 11;   // signed, |g| <= 1020
    localparam int SUM_W         = 21;   // gx^2 + gy^2 <= 2080800
    localparam int SAT_SUM       = 65025;
    localparam int QUEUE_DEPTH   = 2;

    localparam int REG_WIDTH  = 0;
    localparam int REG_HEIGHT = 1;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 14'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 14'd480;

    typedef struct packed {
        logic             cmd;
        logic [PIX_W-1:0] pixel_in;
    } in_word_t;

    typedef struct packed {
        logic             out_valid;
        logic [PIX_W-1:0] magnitude;
        logic             frame_last;
    } out_word_t;

    typedef struct packed {
        logic [GEOM_W-1:0] width;
        logic [CFG_W-1:0]  height;
    } geom_t;

endpackage

// ===== rtl/core/sobm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module sobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/sobm_fifo.sv =====
// Small register queue of generic width.
// Depends on nothing.
module sobm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg,  count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/core/sobm_front.sv =====
// Front end: takes input words, turns a flush word into a zero pixel, queues pixels.
// Depends on sobm_pkg and sobm_fifo.
module sobm_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  sobm_pkg::in_word_t         in_word,
    output logic                       full,
    input  logic                       pop,
    output logic [sobm_pkg::PIX_W-1:0] px,
    output logic                       empty
);

    logic [sobm_pkg::PIX_W-1:0] px_in;

    // a flush word carries no pixel; inside the frame it counts as black
    assign px_in = in_word.cmd ? '0 : in_word.pixel_in;

    sobm_fifo #(
        .WIDTH (sobm_pkg::PIX_W),
        .DEPTH (sobm_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (px_in),
        .full  (full),
        .pop   (pop),
        .rdata (px),
        .empty (empty)
    );

endmodule

// ===== rtl/core/sobm_back.sv =====
// Back end: line stores, 3x3 window, Sobel gradients, iterative square root.
// Depends on sobm_pkg and sobm_ram.
module sobm_back #(
    parameter int MAX_WIDTH = sobm_pkg::MAX_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sobm_pkg::geom_t            geom,
    input  logic                       restart,
    input  logic                       px_empty,
    input  logic [sobm_pkg::PIX_W-1:0] px,
    output logic                       px_pop,
    input  logic                       res_full,
    output logic                       res_push,
    output sobm_pkg::out_word_t        res_word
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int GW = sobm_pkg::GEOM_W;
    localparam int HW = sobm_pkg::CFG_W;
    localparam int PW = sobm_pkg::PIX_W;
    localparam int DW = sobm_pkg::GRAD_W;
    localparam int SW = sobm_pkg::SUM_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CALC = 3'd1;
    localparam logic [2:0] ST_SQ   = 3'd2;
    localparam logic [2:0] ST_ROOT = 3'd3;
    localparam logic [2:0] ST_PUSH = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [PW-1:0]        px_reg;
    logic [PW-1:0]        win_reg [6];
    logic [AW-1:0]        in_col_reg;
    logic [1:0]           in_row_reg;      // saturates at 2
    logic [AW-1:0]        out_col_reg;
    logic [HW-1:0]        out_row_reg;
    logic                 valid_reg, last_reg;
    logic signed [DW-1:0] gx_reg, gy_reg;
    logic [SW-1:0]        sum_reg;
    logic [PW-1:0]        root_reg;
    logic [2:0]           bit_reg;

    logic [PW-1:0]        top_rd, mid_rd;
    logic                 ram_we;

    logic                 valid_c, interior_c, last_c;
    logic [GW:0]          in_col_inc, out_col_inc, out_col_p2;
    logic [HW:0]          out_row_inc, out_row_p2;
    logic signed [DW-1:0] gx_c, gy_c;
    logic [PW-1:0]        trial;
    logic [2*PW-1:0]      trial_sq;

    assign ram_we = (state_reg == ST_CALC);
    assign px_pop = (state_reg == ST_IDLE) && !px_empty && !restart;

    sobm_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_upper (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_col_reg),
        .wdata (mid_rd),
        .raddr (in_col_reg),
        .rdata (top_rd)
    );

    sobm_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_middle (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_col_reg),
        .wdata (px_reg),
        .raddr (in_col_reg),
        .rdata (mid_rd)
    );

    assign in_col_inc  = (GW + 1)'(in_col_reg) + 1'b1;
    assign out_col_inc = (GW + 1)'(out_col_reg) + 1'b1;
    assign out_col_p2  = (GW + 1)'(out_col_reg) + 2'd2;
    assign out_row_inc = (HW + 1)'(out_row_reg) + 1'b1;
    assign out_row_p2  = (HW + 1)'(out_row_reg) + 2'd2;

    always_comb
    begin
        valid_c    = (in_row_reg == 2'd2) || ((in_row_reg == 2'd1) && (in_col_reg != '0));
        interior_c = valid_c && (out_row_reg != '0) && (out_row_p2 <= (HW + 1)'(geom.height))
                     && (out_col_reg != '0) && (out_col_p2 <= (GW + 1)'(geom.width));
        last_c     = valid_c && (out_row_inc >= (HW + 1)'(geom.height))
                     && (out_col_inc >= (GW + 1)'(geom.width));
        // left column minus right column; top row minus bottom row
        gx_c = (DW'(win_reg[0]) + (DW'(win_reg[1]) <<< 1) + DW'(win_reg[2]))
             - (DW'(top_rd) + (DW'(mid_rd) <<< 1) + DW'(px_reg));
        gy_c = (DW'(win_reg[0]) + (DW'(win_reg[3]) <<< 1) + DW'(top_rd))
             - (DW'(win_reg[2]) + (DW'(win_reg[5]) <<< 1) + DW'(px_reg));
        trial    = root_reg | (PW'(1) << bit_reg);
        trial_sq = trial * trial;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (px_pop) state_next = ST_CALC;
            ST_CALC: state_next = ST_SQ;
            ST_SQ:   state_next = ST_ROOT;
            ST_ROOT: if (bit_reg == 3'd0) state_next = ST_PUSH;
            ST_PUSH: if (!res_full) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign res_push             = (state_reg == ST_PUSH);
    assign res_word.out_valid   = valid_reg;
    assign res_word.magnitude   = (sum_reg >= SW'(sobm_pkg::SAT_SUM)) ? '1 : root_reg;
    assign res_word.frame_last  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (restart)
        begin
            state_reg   <= ST_IDLE;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CALC)
            begin
                if (last_c)
                begin
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                    for (int i = 0; i < 6; i++)
                    begin
                        win_reg[i] <= '0;
                    end
                end
                else
                begin
                    win_reg[0] <= win_reg[3];
                    win_reg[1] <= win_reg[4];
                    win_reg[2] <= win_reg[5];
                    win_reg[3] <= top_rd;
                    win_reg[4] <= mid_rd;
                    win_reg[5] <= px_reg;
                    if (in_col_inc >= (GW + 1)'(geom.width))
                    begin
                        in_col_reg <= '0;
                        if (in_row_reg != 2'd2)
                        begin
                            in_row_reg <= in_row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        in_col_reg <= AW'(in_col_inc);
                    end
                    if (valid_c)
                    begin
                        if (out_col_inc >= (GW + 1)'(geom.width))
                        begin
                            out_col_reg <= '0;
                            out_row_reg <= HW'(out_row_inc);
                        end
                        else
                        begin
                            out_col_reg <= AW'(out_col_inc);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (px_pop)
        begin
            px_reg <= px;
        end
        if (state_reg == ST_CALC)
        begin
            valid_reg <= valid_c;
            last_reg  <= last_c;
            gx_reg    <= interior_c ? gx_c : '0;
            gy_reg    <= interior_c ? gy_c : '0;
        end
        if (state_reg == ST_SQ)
        begin
            sum_reg  <= SW'(gx_reg * gx_reg) + SW'(gy_reg * gy_reg);
            root_reg <= '0;
            bit_reg  <= 3'd7;
        end
        if (state_reg == ST_ROOT)
        begin
            if (SW'(trial_sq) <= sum_reg)
            begin
                root_reg <= trial;
            end
            bit_reg <= bit_reg - 1'b1;
        end
    end

endmodule

// ===== rtl/core/sobel_edge_magnitude.sv =====
// Top level of the streaming Sobel edge magnitude block: APB registers, front
// queue, back engine, result queue. Depends on sobm_pkg, sobm_front, sobm_back, sobm_fifo.
//
// Pixels of one frame enter in raster order as words on a queue interface
// (push/full); every word gives one result word (pop/empty), namely the output
// for the raster position image_width+1 words earlier. Output is
// floor(sqrt(Gx^2+Gy^2)) saturated at 255, zero on the border; out_valid is low
// for the first image_width+1 words of a frame, and frame_last marks the last
// output pixel, after which a new frame starts. Drain a frame with
// image_width+1 flush words. The back end takes each word through a line store read,
// a window/gradient step, a squaring step and the bit-by-bit square root, then hands
// it to the result queue (waiting while that is full) before it takes the next word.
// Two-entry queues on both sides let input and output stall independently.
// Registers: image_width at 0x0, image_height at 0x4 (14 bits each); any write
// restarts the frame. Width is used clamped to [3, MAX_WIDTH], height with a
// floor of 3. Write registers only while the block is idle.
module sobel_edge_magnitude #(
    parameter int MAX_WIDTH = sobm_pkg::MAX_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sobm_pkg::in_word_t  in_word,
    output logic                full,
    input  logic                pop,
    output sobm_pkg::out_word_t out_word,
    output logic                empty,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int GW = sobm_pkg::GEOM_W;
    localparam int HW = sobm_pkg::CFG_W;

    logic [HW-1:0]              width_reg, height_reg;
    logic                       cfg_wr;
    sobm_pkg::geom_t            geom;
    logic                       px_pop, px_empty;
    logic [sobm_pkg::PIX_W-1:0] px;
    logic                       res_push, res_full;
    sobm_pkg::out_word_t        res_word;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= sobm_pkg::WIDTH_RST;
            height_reg <= sobm_pkg::HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            case (32'(paddr[2]))
                sobm_pkg::REG_WIDTH:  width_reg  <= pwdata[HW-1:0];
                sobm_pkg::REG_HEIGHT: height_reg <= pwdata[HW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (32'(paddr[2]))
            sobm_pkg::REG_WIDTH:  prdata = 32'(width_reg);
            sobm_pkg::REG_HEIGHT: prdata = 32'(height_reg);
            default:              prdata = '0;
        endcase
    end

    // effective geometry
    always_comb
    begin
        if (width_reg < HW'(3))
        begin
            geom.width = GW'(3);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            geom.width = GW'(MAX_WIDTH);
        end
        else
        begin
            geom.width = GW'(width_reg);
        end
        geom.height = (height_reg < HW'(3)) ? HW'(3) : height_reg;
    end

    sobm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .in_word (in_word),
        .full    (full),
        .pop     (px_pop),
        .px      (px),
        .empty   (px_empty)
    );

    sobm_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .geom     (geom),
        .restart  (cfg_wr),
        .px_empty (px_empty),
        .px       (px),
        .px_pop   (px_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res_word (res_word)
    );

    sobm_fifo #(
        .WIDTH ($bits(sobm_pkg::out_word_t)),
        .DEPTH (sobm_pkg::QUEUE_DEPTH)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_word),
        .full  (res_full),
        .pop   (pop),
        .rdata (out_word),
        .empty (empty)
    );

endmodule
